/* sv/nns_pkg.sv */
// Package for the nearest neighbor scaler: field widths, config register
// indexes and the structs passed between the front, queue, divider and back.
// No dependencies.
package nns_pkg;

    localparam int MODE_W     = 1;
    localparam int LIDX_W     = 17;
    localparam int PIX_W      = 32;
    localparam int COORD_W    = 11;
    localparam int DADDR_W    = 23;

    localparam int SW_W       = 10;
    localparam int SH_W       = 9;
    localparam int DW_W       = 12;
    localparam int DH_W       = 12;
    localparam int STR_W      = 13;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_STRIDE = 3'd4;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    // product width of dest_y * stride + dest_x before wrap
    localparam int AMUL_W     = COORD_W + STR_W + 1;
    // raw source index: sy*src_width + sx, also holds a load index
    localparam int RAW_W      = 20;
    // quotient bits of one coordinate division, bounded by src_width
    localparam int Q_W        = SW_W;
    // dividend: coord * src size
    localparam int DVD_W      = COORD_W + SW_W;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_ITERS  = Q_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_ITERS + 1);

    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [SW_W-1:0]  src_width;
        logic [SH_W-1:0]  src_height;
        logic [DW_W-1:0]  dst_width;
        logic [DH_W-1:0]  dst_height;
        logic [STR_W-1:0] dst_stride;
    } t_cfg;

    typedef struct packed {
        logic               is_fetch;
        logic               ok;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DADDR_W-1:0] addr;
        logic [LIDX_W-1:0]  load_idx;
        logic [PIX_W-1:0]   load_pixel;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DW_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } t_div_rsp;

endpackage

/* sv/nns_in_if.sv */
// Input item channel of the scaler: valid/ready plus load and fetch fields.
// Depends on nns_pkg.
interface nns_in_if;
    logic                          valid;
    logic                          ready;
    logic [nns_pkg::MODE_W-1:0]    mode;
    logic [nns_pkg::LIDX_W-1:0]    load_index;
    logic [nns_pkg::PIX_W-1:0]     load_pixel;
    logic [nns_pkg::COORD_W-1:0]   dest_x;
    logic [nns_pkg::COORD_W-1:0]   dest_y;

    modport source(output valid, mode, load_index, load_pixel, dest_x, dest_y,
                   input ready);
    modport sink(input valid, mode, load_index, load_pixel, dest_x, dest_y,
                 output ready);
endinterface

/* sv/nns_out_if.sv */
// Result item channel of the scaler: valid/ready plus pixel, address, flag.
// Depends on nns_pkg.
interface nns_out_if;
    logic                          valid;
    logic                          ready;
    logic [nns_pkg::PIX_W-1:0]     out_pixel;
    logic [nns_pkg::DADDR_W-1:0]   dest_address;
    logic                          out_valid;

    modport source(output valid, out_pixel, dest_address, out_valid, input ready);
    modport sink(input valid, out_pixel, dest_address, out_valid, output ready);
endinterface

/* sv/nearest_neighbor_scaler_unit.sv */
// Nearest neighbor scaler with source frame store.
// Input channel i_item (valid/ready): mode 0 loads load_pixel at load_index,
// mode 1 fetches the source pixel nearest to (dest_x, dest_y).
// Output channel o_result (valid/ready): one item per fetch, none per load,
// carrying out_pixel, dest_address = dest_y*dst_stride+dest_x and out_valid.
// Config port: i_cfg_we/i_cfg_idx/i_cfg_data, to be written by the user only
// while idle; the block itself does not enforce this. A fetch occupies the
// back end for two coordinate divisions on the shared 2-bit-per-cycle
// divider plus the index multiply, frame store read and output load; a fetch
// that fails the bounds check skips all but the output load. When the frame
// depth is not a power of two, each load and each in-bounds fetch adds an
// index reduction.
// A 2-entry queue sits between the input stage and the back end, so items are
// still accepted while a result waits in the output register.
// Reset clears config registers, the queue and all control state; the frame
// store is not cleared and must be loaded before it is fetched.
// When the receiver stalls, the result holds and the back end waits on it.
// Depends on nns_pkg, nns_in_if, nns_out_if and the nns_* submodules.
module nearest_neighbor_scaler_unit #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_DST_DIM    = 2048
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [nns_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [nns_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    nns_in_if.sink                           i_item,
    nns_out_if.source                        o_result
);
    import nns_pkg::*;

    localparam int FRAME_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

    t_cfg     r_cfg;
    logic     w_push;
    t_entry   w_push_ent;
    logic     w_full;
    logic     w_q_vld;
    t_entry   w_q_ent;
    logic     w_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data[SW_W-1:0];
                CFG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_data[SH_W-1:0];
                CFG_DST_WIDTH:  r_cfg.dst_width  <= i_cfg_data[DW_W-1:0];
                CFG_DST_HEIGHT: r_cfg.dst_height <= i_cfg_data[DH_W-1:0];
                CFG_DST_STRIDE: r_cfg.dst_stride <= i_cfg_data[STR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    nns_front #(
        .MAX_DST_DIM(MAX_DST_DIM)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (i_item),
        .o_push  (w_push),
        .o_ent   (w_push_ent),
        .i_full  (w_full)
    );

    nns_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_push_ent),
        .o_full  (w_full),
        .o_vld   (w_q_vld),
        .o_ent   (w_q_ent),
        .i_pop   (w_pop)
    );

    nns_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    nns_back #(
        .DEPTH(FRAME_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_vld   (w_q_vld),
        .i_q_ent   (w_q_ent),
        .o_q_pop   (w_pop),
        .o_div_req (w_div_req),
        .i_div_rsp (w_div_rsp),
        .o_result  (o_result)
    );
endmodule

/* sv/nns_front.sv */
// Front end: takes input items, checks fetch bounds, forms the destination
// address and hands a classified entry to the queue. Depends on nns_pkg.
module nns_front #(
    parameter int MAX_DST_DIM = 2048
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nns_pkg::t_cfg   i_cfg,
    nns_in_if.sink          i_item,
    output logic            o_push,
    output nns_pkg::t_entry o_ent,
    input  logic            i_full
);
    import nns_pkg::*;

    logic               r_vld;
    logic               r_mode;
    logic [LIDX_W-1:0]  r_lidx;
    logic [PIX_W-1:0]   r_pix;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;

    logic               w_accept;
    logic               w_ok;
    logic [AMUL_W-1:0]  w_addr;

    assign i_item.ready = !r_vld || !i_full;
    assign w_accept     = i_item.valid && i_item.ready;
    assign o_push       = r_vld && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_item.mode;
            r_lidx <= i_item.load_index;
            r_pix  <= i_item.load_pixel;
            r_x    <= i_item.dest_x;
            r_y    <= i_item.dest_y;
        end
    end

    assign w_ok = (i_cfg.src_width != '0) && (i_cfg.src_height != '0)
               && (i_cfg.dst_width != '0) && (i_cfg.dst_height != '0)
               && (DW_W'(r_x) < i_cfg.dst_width) && (DH_W'(r_y) < i_cfg.dst_height)
               && (32'(r_x) < 32'(MAX_DST_DIM)) && (32'(r_y) < 32'(MAX_DST_DIM));

    assign w_addr = AMUL_W'(r_y) * AMUL_W'(i_cfg.dst_stride) + AMUL_W'(r_x);

    always_comb begin
        o_ent.is_fetch   = (r_mode == MODE_FETCH);
        o_ent.ok         = w_ok;
        o_ent.x          = r_x;
        o_ent.y          = r_y;
        o_ent.addr       = w_ok ? w_addr[DADDR_W-1:0] : '0;
        o_ent.load_idx   = r_lidx;
        o_ent.load_pixel = r_pix;
    end
endmodule

/* sv/nns_fifo.sv */
// Two-entry queue between the front end and the back end.
// Depends on nns_pkg.
module nns_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nns_pkg::t_entry i_ent,
    output logic            o_full,
    output logic            o_vld,
    output nns_pkg::t_entry o_ent,
    input  logic            i_pop
);
    import nns_pkg::*;

    t_entry              r_slot [QDEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_cnt;

    logic w_push;
    logic w_pop;

    assign o_full = (r_cnt == QCNT_W'(QDEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_ent  = r_slot[r_rp];
    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_ent;
        end
    end
endmodule

/* sv/nns_div.sv */
// Shared restoring divider, two quotient bits per cycle. Requires the
// dividend to be below divisor * 2^Q_W. Depends on nns_pkg.
module nns_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nns_pkg::t_div_req i_req,
    output nns_pkg::t_div_rsp o_rsp
);
    import nns_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DW_W-1:0]      r_rem;
    logic [Q_W-1:0]       r_q;
    logic [DW_W-1:0]      r_dvs;

    logic [DW_W-1:0]      n_rem;
    logic [Q_W-1:0]       n_q;

    always_comb begin
        logic [DW_W:0] t;
        n_rem = r_rem;
        n_q   = r_q;
        for (int s = 0; s < DIV_STEPS; s++) begin
            t   = {n_rem, n_q[Q_W-1]};
            n_q = {n_q[Q_W-2:0], 1'b0};
            if (t >= {1'b0, r_dvs}) begin
                n_rem  = DW_W'(t - {1'b0, r_dvs});
                n_q[0] = 1'b1;
            end else begin
                n_rem = t[DW_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_ITERS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= DW_W'(i_req.dividend >> Q_W);
            r_q   <= i_req.dividend[Q_W-1:0];
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
endmodule

/* sv/nns_back.sv */
// Back end: frame store, coordinate mapping through the shared divider,
// index reduction and the output register. Depends on nns_pkg, nns_out_if.
module nns_back #(
    parameter int DEPTH = 131072
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nns_pkg::t_cfg     i_cfg,
    input  logic              i_q_vld,
    input  nns_pkg::t_entry   i_q_ent,
    output logic              o_q_pop,
    output nns_pkg::t_div_req o_div_req,
    input  nns_pkg::t_div_rsp i_div_rsp,
    nns_out_if.source         o_result
);
    import nns_pkg::*;

    localparam int  ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam bit  POW2    = ((DEPTH & (DEPTH - 1)) == 0);
    // idx / DEPTH as (idx * MOD_M) >> MOD_SH, exact for any idx below 2^RAW_W
    localparam int  MOD_SH  = RAW_W + ADDR_W;
    localparam int  MOD_M_W = RAW_W + 1;
    localparam int  PROD_W  = RAW_W + MOD_M_W;
    localparam logic [MOD_M_W-1:0] MOD_M =
        MOD_M_W'(((64'd1 << MOD_SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

    typedef enum logic [3:0] {
        S_IDLE, S_MULX, S_DSTX, S_WAITX, S_MULY, S_DSTY, S_WAITY,
        S_MULI, S_MOD, S_MODR, S_WRITE, S_READ, S_OUT
    } t_state;

    t_state             r_state;
    t_entry             r_ent;
    logic [DVD_W-1:0]   r_prod;
    logic [Q_W-1:0]     r_sx;
    logic [Q_W-1:0]     r_sy;
    logic [RAW_W-1:0]   r_idx;
    logic [RAW_W-1:0]   r_mq;
    logic [PIX_W-1:0]   r_rd;
    logic [PIX_W-1:0]   r_frame [DEPTH];

    logic               r_out_vld;
    logic [PIX_W-1:0]   r_out_pixel;
    logic [DADDR_W-1:0] r_out_addr;
    logic               r_out_ok;

    logic [PROD_W-1:0]  w_mod_prod;
    logic [RAW_W-1:0]   w_mod_q;
    logic [ADDR_W-1:0]  w_addr;
    logic [RAW_W-1:0]   w_mask_idx;
    logic               w_out_take;
    logic               w_out_load;

    assign o_q_pop    = (r_state == S_IDLE) && i_q_vld;
    assign w_out_take = r_out_vld && o_result.ready;
    assign w_out_load = (r_state == S_OUT) && (!r_out_vld || o_result.ready);

    assign o_div_req.start    = (r_state == S_DSTX) || (r_state == S_DSTY);
    assign o_div_req.dividend = r_prod;
    assign o_div_req.divisor  = (r_state == S_DSTX) ? i_cfg.dst_width : i_cfg.dst_height;

    assign w_mod_prod = PROD_W'(r_idx) * PROD_W'(MOD_M);
    assign w_mod_q    = RAW_W'(w_mod_prod >> MOD_SH);
    assign w_mask_idx = r_idx & RAW_W'(DEPTH - 1);
    assign w_addr     = POW2 ? ADDR_W'(w_mask_idx) : ADDR_W'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            if (w_out_take && !w_out_load) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_vld) begin
                        r_ent <= i_q_ent;
                        r_idx <= RAW_W'(i_q_ent.load_idx);
                        if (!i_q_ent.is_fetch) begin
                            r_state <= POW2 ? S_WRITE : S_MOD;
                        end else if (!i_q_ent.ok) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MULX;
                        end
                    end
                end
                S_MULX: begin
                    r_prod  <= DVD_W'(r_ent.x) * DVD_W'(i_cfg.src_width);
                    r_state <= S_DSTX;
                end
                S_DSTX: begin
                    r_state <= S_WAITX;
                end
                S_WAITX: begin
                    if (i_div_rsp.done) begin
                        r_sx    <= i_div_rsp.quot;
                        r_state <= S_MULY;
                    end
                end
                S_MULY: begin
                    r_prod  <= DVD_W'(r_ent.y) * DVD_W'(i_cfg.src_height);
                    r_state <= S_DSTY;
                end
                S_DSTY: begin
                    r_state <= S_WAITY;
                end
                S_WAITY: begin
                    if (i_div_rsp.done) begin
                        r_sy    <= i_div_rsp.quot;
                        r_state <= S_MULI;
                    end
                end
                S_MULI: begin
                    r_idx   <= RAW_W'(RAW_W'(r_sy) * RAW_W'(i_cfg.src_width)) + RAW_W'(r_sx);
                    r_state <= POW2 ? S_READ : S_MOD;
                end
                S_MOD: begin
                    r_mq    <= w_mod_q;
                    r_state <= S_MODR;
                end
                S_MODR: begin
                    r_idx   <= r_idx - RAW_W'(r_mq * RAW_W'(DEPTH));
                    r_state <= r_ent.is_fetch ? S_READ : S_WRITE;
                end
                S_WRITE: begin
                    r_state <= S_IDLE;
                end
                S_READ: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out_vld   <= 1'b1;
                        r_out_pixel <= r_ent.ok ? r_rd : '0;
                        r_out_addr  <= r_ent.addr;
                        r_out_ok    <= r_ent.ok;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_frame[w_addr] <= r_ent.load_pixel;
        end
        if (r_state == S_READ) begin
            r_rd <= r_frame[w_addr];
        end
    end

    assign o_result.valid        = r_out_vld;
    assign o_result.out_pixel    = r_out_pixel;
    assign o_result.dest_address = r_out_addr;
    assign o_result.out_valid    = r_out_ok;
endmodule

/* sv/nns_chk.sv */
// Port-level checker for the scaler result channel, bound to the top level.
// Depends on nns_pkg.
module nns_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [nns_pkg::PIX_W-1:0]     i_out_pixel,
    input logic [nns_pkg::DADDR_W-1:0]   i_dest_address,
    input logic                          i_out_valid
);
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> i_valid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> ($stable(i_out_pixel) && $stable(i_dest_address)
                                   && $stable(i_out_valid)))
        else $error("result payload changed while stalled");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_out_valid) |-> (i_out_pixel == '0 && i_dest_address == '0))
        else $error("rejected fetch carries nonzero fields");
endmodule

bind nearest_neighbor_scaler_unit nns_chk u_nns_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_result.valid),
    .i_ready        (o_result.ready),
    .i_out_pixel    (o_result.out_pixel),
    .i_dest_address (o_result.dest_address),
    .i_out_valid    (o_result.out_valid)
);
